// ===== rtl/tfcp_pkg.sv =====
// Package for the typed frame checksum parser.
// Holds widths, register indexes, reset values, status codes and shared structs.
// No dependencies; every other rtl file imports it.
`default_nettype none

package tfcp_pkg;

  localparam int BYTE_W      = 8;
  localparam int COUNT_BITS  = 16;
  localparam int OUT_COUNT_W = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TYPE_QUERY    = 4'd0,
    REG_TYPE_RESPONSE = 4'd1,
    REG_TYPE_WAKEUP   = 4'd2,
    REG_SUB_WAKEUP    = 4'd3,
    REG_SUB_INIT      = 4'd4,
    REG_SUB_SUBGROUP  = 4'd5,
    REG_SUB_TABLE     = 4'd6,
    REG_MIN_SIZE      = 4'd7
  } tfcp_reg_t;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] RST_TYPE_QUERY    = 8'd114;
  localparam logic [BYTE_W-1:0] RST_TYPE_RESPONSE = 8'd2;
  localparam logic [BYTE_W-1:0] RST_TYPE_WAKEUP   = 8'd254;
  localparam logic [BYTE_W-1:0] RST_SUB_WAKEUP    = 8'd255;
  localparam logic [BYTE_W-1:0] RST_SUB_INIT      = 8'd0;
  localparam logic [BYTE_W-1:0] RST_SUB_SUBGROUP  = 8'd114;
  localparam logic [BYTE_W-1:0] RST_SUB_TABLE     = 8'd113;
  localparam logic [BYTE_W-1:0] RST_MIN_SIZE      = 8'd4;

  // Frame status codes
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SUM = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] type_query;
    logic [BYTE_W-1:0] type_response;
    logic [BYTE_W-1:0] type_wakeup;
    logic [BYTE_W-1:0] sub_wakeup;
    logic [BYTE_W-1:0] sub_init;
    logic [BYTE_W-1:0] sub_subgroup;
    logic [BYTE_W-1:0] sub_table;
    logic [BYTE_W-1:0] min_size;
  } tfcp_cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    frame_status;
    logic [BYTE_W-1:0]      frame_type;
    logic [BYTE_W-1:0]      frame_subtype;
    logic [BYTE_W-1:0]      frame_size;
    logic                   payload_valid;
    logic [BYTE_W-1:0]      payload_byte;
    logic [BYTE_W-1:0]      payload_index;
    logic [OUT_COUNT_W-1:0] good_frames;
    logic [OUT_COUNT_W-1:0] bad_frames;
  } tfcp_result_t;

endpackage

`default_nettype wire

// ===== rtl/tfcp_if.sv =====
// Channel interfaces of the typed frame checksum parser: byte input,
// result output and configuration write. Depends on tfcp_pkg.
`default_nettype none

interface tfcp_in_if
  import tfcp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfcp_out_if
  import tfcp_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    frame_status;
  logic [BYTE_W-1:0]      frame_type;
  logic [BYTE_W-1:0]      frame_subtype;
  logic [BYTE_W-1:0]      frame_size;
  logic                   payload_valid;
  logic [BYTE_W-1:0]      payload_byte;
  logic [BYTE_W-1:0]      payload_index;
  logic [OUT_COUNT_W-1:0] good_frames;
  logic [OUT_COUNT_W-1:0] bad_frames;

  modport source (output valid, output frame_status, output frame_type,
                  output frame_subtype, output frame_size, output payload_valid,
                  output payload_byte, output payload_index, output good_frames,
                  output bad_frames, input ready);
  modport sink   (input valid, input frame_status, input frame_type,
                  input frame_subtype, input frame_size, input payload_valid,
                  input payload_byte, input payload_index, input good_frames,
                  input bad_frames, output ready);
endinterface

interface tfcp_cfg_if
  import tfcp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tfcp_cfg_regs.sv =====
// Configuration register file of the typed frame checksum parser.
// Decodes register writes by index; depends on tfcp_pkg.
`default_nettype none

module tfcp_cfg_regs
  import tfcp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [BYTE_W-1:0]    wr_data,
  output tfcp_cfg_t                 cfg
);

  tfcp_cfg_t cfg_r;
  tfcp_cfg_t cfg_nxt;

  // Decode the write; indexes past the last register are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (tfcp_reg_t'(wr_index))
        REG_TYPE_QUERY:    cfg_nxt.type_query    = wr_data;
        REG_TYPE_RESPONSE: cfg_nxt.type_response = wr_data;
        REG_TYPE_WAKEUP:   cfg_nxt.type_wakeup   = wr_data;
        REG_SUB_WAKEUP:    cfg_nxt.sub_wakeup    = wr_data;
        REG_SUB_INIT:      cfg_nxt.sub_init      = wr_data;
        REG_SUB_SUBGROUP:  cfg_nxt.sub_subgroup  = wr_data;
        REG_SUB_TABLE:     cfg_nxt.sub_table     = wr_data;
        REG_MIN_SIZE:      cfg_nxt.min_size      = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.type_query    <= RST_TYPE_QUERY;
      cfg_r.type_response <= RST_TYPE_RESPONSE;
      cfg_r.type_wakeup   <= RST_TYPE_WAKEUP;
      cfg_r.sub_wakeup    <= RST_SUB_WAKEUP;
      cfg_r.sub_init      <= RST_SUB_INIT;
      cfg_r.sub_subgroup  <= RST_SUB_SUBGROUP;
      cfg_r.sub_table     <= RST_SUB_TABLE;
      cfg_r.min_size      <= RST_MIN_SIZE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/tfcp_parser.sv =====
// Frame parser state machine: type, size, subtype, payload, checksum.
// Advances one byte per step and forms the result; depends on tfcp_pkg.
`default_nettype none

module tfcp_parser
  import tfcp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire tfcp_cfg_t         cfg,
  output tfcp_result_t           res
);

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_SIZE = 3'd1,
    PH_SUB  = 3'd2,
    PH_DATA = 3'd3,
    PH_CSUM = 3'd4
  } phase_t;

  phase_t                phase_r,    phase_nxt;
  logic [BYTE_W-1:0]     type_r,     type_nxt;
  logic [BYTE_W-1:0]     sub_r,      sub_nxt;
  logic [BYTE_W-1:0]     size_r,     size_nxt;
  logic [BYTE_W-1:0]     plen_r,     plen_nxt;
  logic [BYTE_W-1:0]     pseen_r,    pseen_nxt;
  logic [BYTE_W-1:0]     sum_r,      sum_nxt;
  logic [COUNT_BITS-1:0] good_r,     good_nxt;
  logic [COUNT_BITS-1:0] bad_r,      bad_nxt;

  logic type_ok;
  logic sub_ok;
  logic sum_ok;

  // Match the byte against the configured codes
  assign type_ok = (rx_byte == cfg.type_query) || (rx_byte == cfg.type_response) ||
                   (rx_byte == cfg.type_wakeup);
  assign sub_ok  = (rx_byte == cfg.sub_wakeup) || (rx_byte == cfg.sub_init) ||
                   (rx_byte == cfg.sub_subgroup) || (rx_byte == cfg.sub_table);
  assign sum_ok  = (BYTE_W'(~sum_r + 8'd1) == rx_byte);

  // Next state and result for the current byte
  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    sub_nxt   = sub_r;
    size_nxt  = size_r;
    plen_nxt  = plen_r;
    pseen_nxt = pseen_r;
    sum_nxt   = sum_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;

    res.frame_status  = ST_NONE;
    res.payload_valid = 1'b0;
    res.payload_byte  = '0;
    res.payload_index = '0;

    case (phase_r)
      PH_SIZE: begin
        // Hold in this phase until a legal size byte arrives
        if (rx_byte >= cfg.min_size) begin
          size_nxt  = rx_byte;
          plen_nxt  = rx_byte - cfg.min_size;
          sum_nxt   = sum_r + rx_byte;
          phase_nxt = PH_SUB;
        end
      end
      PH_SUB: begin
        if (sub_ok) begin
          sub_nxt   = rx_byte;
          sum_nxt   = sum_r + rx_byte;
          pseen_nxt = '0;
          phase_nxt = (plen_r != '0) ? PH_DATA : PH_CSUM;
        end else begin
          bad_nxt   = bad_r + COUNT_BITS'(1);
          phase_nxt = PH_TYPE;
        end
      end
      PH_DATA: begin
        // Stream the payload byte out with its position
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = pseen_r;
        pseen_nxt         = pseen_r + 8'd1;
        sum_nxt           = sum_r + rx_byte;
        if (pseen_nxt == plen_r) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (sum_ok) begin
          good_nxt         = good_r + COUNT_BITS'(1);
          res.frame_status = ST_OK;
        end else begin
          bad_nxt          = bad_r + COUNT_BITS'(1);
          res.frame_status = ST_BAD_SUM;
        end
        phase_nxt = PH_TYPE;
      end
      default: begin
        // Waiting for a type byte; skip anything that does not match
        if (type_ok) begin
          type_nxt  = rx_byte;
          plen_nxt  = '0;
          sum_nxt   = rx_byte;
          phase_nxt = PH_SIZE;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
    endcase

    res.frame_type    = type_nxt;
    res.frame_subtype = sub_nxt;
    res.frame_size    = size_nxt;
    res.good_frames   = OUT_COUNT_W'(good_nxt);
    res.bad_frames    = OUT_COUNT_W'(bad_nxt);
  end

  // Hold parser state; advance only on a step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      type_r  <= '0;
      sub_r   <= '0;
      size_r  <= '0;
      plen_r  <= '0;
      pseen_r <= '0;
      sum_r   <= '0;
      good_r  <= '0;
      bad_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      sub_r   <= sub_nxt;
      size_r  <= size_nxt;
      plen_r  <= plen_nxt;
      pseen_r <= pseen_nxt;
      sum_r   <= sum_nxt;
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/typed_frame_checksum_parser.sv =====
// Typed frame checksum parser.
//
// in_bus carries one received byte per transaction (valid/ready). Each byte
// gives exactly one transaction on out_bus: the frame status (no end, ok or
// bad checksum), the held type, subtype and size bytes, the payload byte with
// its index when the byte was payload, and the good and bad frame counters.
// Payload is streamed, never buffered.
//
// cfg_bus writes the eight code and size registers by index; it is always
// ready. Write it only while no byte is in flight.
//
// A byte passes through the input register, then the parser state machine and
// its byte adder feeding the result register. Throughput is one byte per
// cycle while out_bus does not stall.
//
// A stall on out_bus holds the result register; the input register still
// takes a byte if it is empty, then in_bus.ready stays low until the result
// is taken.
// Synchronous reset clears the pipeline, the parser state and the counters,
// and restores the register reset values.
// Depends on tfcp_pkg, tfcp_if, tfcp_cfg_regs and tfcp_parser.
`default_nettype none

module typed_frame_checksum_parser
  import tfcp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  tfcp_in_if.sink     in_bus,
  tfcp_out_if.source  out_bus,
  tfcp_cfg_if.sink    cfg_bus
);

  tfcp_cfg_t         cfg;
  tfcp_result_t      res;
  tfcp_result_t      res_r;
  logic              in_v_r,  in_v_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              out_v_r, out_v_nxt;
  logic              adv;
  logic              in_take;
  logic              step;

  assign cfg_bus.ready = 1'b1;

  tfcp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_bus.valid),
    .wr_index (cfg_bus.index),
    .wr_data  (cfg_bus.data),
    .cfg      (cfg)
  );

  // Pipeline handshake
  assign adv          = !out_v_r || out_bus.ready;
  assign in_bus.ready = !in_v_r || adv;
  assign in_take      = in_bus.valid && in_bus.ready;
  assign step         = in_v_r && adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = adv ? in_v_r : out_v_r;
  end

  tfcp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers: load on acceptance or step, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_bus.rx_byte;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.frame_status  = res_r.frame_status;
  assign out_bus.frame_type    = res_r.frame_type;
  assign out_bus.frame_subtype = res_r.frame_subtype;
  assign out_bus.frame_size    = res_r.frame_size;
  assign out_bus.payload_valid = res_r.payload_valid;
  assign out_bus.payload_byte  = res_r.payload_byte;
  assign out_bus.payload_index = res_r.payload_index;
  assign out_bus.good_frames   = res_r.good_frames;
  assign out_bus.bad_frames    = res_r.bad_frames;

endmodule

`default_nettype wire

// ===== bench/typed_frame_checksum_parser_tb.sv =====
// Testbench for the typed frame checksum parser: directed frames, then random frame streams
// under four idle/stall mixes; results checked against a cycle-free model or typed-in values.
// Depends on tfcp_pkg, tfcp_if and the typed_frame_checksum_parser RTL.
`timescale 1ns / 1ps

module typed_frame_checksum_parser_tb;
  import tfcp_pkg::*;

  localparam int REG_COUNT    = REG_MIN_SIZE + 1;
  localparam int PHASE_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 40;

  typedef enum logic [2:0] {
    WAIT_TYPE, WAIT_SIZE, WAIT_SUB, IN_PAYLOAD, WAIT_CSUM
  } parse_phase_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [BYTE_W-1:0]    value;
    logic                 known;
    tfcp_result_t         want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tfcp_in_if  in_ch ();
  tfcp_out_if out_ch ();
  tfcp_cfg_if cfg_ch ();

  typed_frame_checksum_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch),
    .cfg_bus(cfg_ch)
  );

  // Parser model state and its copy of the registers
  logic [BYTE_W-1:0]     code_reg [REG_COUNT];
  parse_phase_t          phase;
  logic [BYTE_W-1:0]     held_type;
  logic [BYTE_W-1:0]     held_sub;
  logic [BYTE_W-1:0]     held_size;
  logic [BYTE_W-1:0]     pay_len;
  logic [BYTE_W-1:0]     pay_seen;
  logic [BYTE_W-1:0]     run_sum;
  logic [COUNT_BITS-1:0] good_cnt;
  logic [COUNT_BITS-1:0] bad_cnt;

  tfcp_result_t    result_q [$];
  stim_row_t       dir_tab [$];
  logic [BYTE_W-1:0] next_cfg [REG_COUNT];

  // Tag of the byte currently offered on the input channel
  logic            cur_known;
  tfcp_result_t    cur_want;

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int items_sent;
  int err_cnt;
  int cycle_cnt;

  always #6 clk = ~clk;

  function automatic bit type_hit(logic [BYTE_W-1:0] b);
    return b == code_reg[REG_TYPE_QUERY] || b == code_reg[REG_TYPE_RESPONSE] ||
           b == code_reg[REG_TYPE_WAKEUP];
  endfunction

  function automatic bit sub_hit(logic [BYTE_W-1:0] b);
    return b == code_reg[REG_SUB_WAKEUP] || b == code_reg[REG_SUB_INIT] ||
           b == code_reg[REG_SUB_SUBGROUP] || b == code_reg[REG_SUB_TABLE];
  endfunction

  function automatic void reset_model();
    code_reg[REG_TYPE_QUERY]    = RST_TYPE_QUERY;
    code_reg[REG_TYPE_RESPONSE] = RST_TYPE_RESPONSE;
    code_reg[REG_TYPE_WAKEUP]   = RST_TYPE_WAKEUP;
    code_reg[REG_SUB_WAKEUP]    = RST_SUB_WAKEUP;
    code_reg[REG_SUB_INIT]      = RST_SUB_INIT;
    code_reg[REG_SUB_SUBGROUP]  = RST_SUB_SUBGROUP;
    code_reg[REG_SUB_TABLE]     = RST_SUB_TABLE;
    code_reg[REG_MIN_SIZE]      = RST_MIN_SIZE;
    phase     = WAIT_TYPE;
    held_type = '0;
    held_sub  = '0;
    held_size = '0;
    pay_len   = '0;
    pay_seen  = '0;
    run_sum   = '0;
    good_cnt  = '0;
    bad_cnt   = '0;
  endfunction

  // Advance the parser model by one byte and return the result it produces
  function automatic tfcp_result_t parse_byte(logic [BYTE_W-1:0] b);
    tfcp_result_t      r;
    logic [BYTE_W-1:0] sum_neg;
    r = '0;
    r.frame_status = ST_NONE;
    case (phase)
      WAIT_SIZE: begin
        if (b >= code_reg[REG_MIN_SIZE]) begin
          held_size = b;
          pay_len   = b - code_reg[REG_MIN_SIZE];
          run_sum   = run_sum + b;
          phase     = WAIT_SUB;
        end
      end
      WAIT_SUB: begin
        if (sub_hit(b)) begin
          held_sub = b;
          run_sum  = run_sum + b;
          pay_seen = '0;
          phase    = (pay_len != 0) ? IN_PAYLOAD : WAIT_CSUM;
        end else begin
          bad_cnt = bad_cnt + 1'b1;
          phase   = WAIT_TYPE;
        end
      end
      IN_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = pay_seen;
        pay_seen = pay_seen + 1'b1;
        run_sum  = run_sum + b;
        if (pay_seen == pay_len) phase = WAIT_CSUM;
      end
      WAIT_CSUM: begin
        sum_neg = 8'h00 - run_sum;
        if (sum_neg == b) begin
          good_cnt = good_cnt + 1'b1;
          r.frame_status = ST_OK;
        end else begin
          bad_cnt = bad_cnt + 1'b1;
          r.frame_status = ST_BAD_SUM;
        end
        phase = WAIT_TYPE;
      end
      default: begin
        if (type_hit(b)) begin
          held_type = b;
          pay_len   = '0;
          run_sum   = b;
          phase     = WAIT_SIZE;
        end else begin
          phase = WAIT_TYPE;
        end
      end
    endcase
    r.frame_type    = held_type;
    r.frame_subtype = held_sub;
    r.frame_size    = held_size;
    r.good_frames   = OUT_COUNT_W'(good_cnt);
    r.bad_frames    = OUT_COUNT_W'(bad_cnt);
    return r;
  endfunction

  function automatic tfcp_result_t known_result(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] t,
                                                logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] sz,
                                                int g, int bd);
    tfcp_result_t r;
    r = '0;
    r.frame_status  = st;
    r.frame_type    = t;
    r.frame_subtype = s;
    r.frame_size    = sz;
    r.good_frames   = OUT_COUNT_W'(g);
    r.bad_frames    = OUT_COUNT_W'(bd);
    return r;
  endfunction

  function automatic void add_row(row_kind_t kind, logic [CFG_IDX_W-1:0] idx,
                                  logic [BYTE_W-1:0] value, logic known, tfcp_result_t want);
    stim_row_t row;
    row.kind    = kind;
    row.reg_idx = idx;
    row.value   = value;
    row.known   = known;
    row.want    = want;
    dir_tab.push_back(row);
  endfunction

  task automatic report_error(string msg);
    if (err_cnt < PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Offer one byte; hold valid high until the transaction completes
  task automatic push_byte(logic [BYTE_W-1:0] b, logic known = 1'b0, tfcp_result_t want = '0);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    cur_known     <= known;
    cur_want      <= want;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Wait until every expected result has been taken, then let the pipeline settle
  task automatic drain();
    do @(posedge clk); while (result_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    drain();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config();
    tfcp_reg_t r;
    r = r.first();
    settle();
    forever begin
      write_reg(r, next_cfg[r]);
      if (r == r.last()) break;
      r = r.next();
    end
    // Out-of-range index: must leave every register as it is
    write_reg(CFG_IDX_W'(REG_COUNT + $urandom_range((1 << CFG_IDX_W) - 1 - REG_COUNT)),
              BYTE_W'($urandom_range(255)));
  endtask

  // Send one random unit: mostly a well-formed frame, sometimes noise or a broken frame
  task automatic send_frame();
    int                kind;
    int                plen;
    int                max_len;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    kind = $urandom_range(99);
    if (kind < 6) begin
      do b = BYTE_W'($urandom_range(255)); while (type_hit(b));
      push_byte(b);
    end else if (kind < 9) begin
      push_byte(BYTE_W'($urandom_range(255)));
    end else begin
      b = code_reg[REG_TYPE_QUERY + $urandom_range(2)];
      push_byte(b);
      sum = b;
      max_len = 255 - code_reg[REG_MIN_SIZE];
      if ($urandom_range(59) == 0) plen = max_len;
      else plen = $urandom_range(max_len < 6 ? max_len : 6);
      // Undersized size byte: skipped while waiting for the real one
      if (kind < 15 && code_reg[REG_MIN_SIZE] != 0)
        push_byte(BYTE_W'($urandom_range(code_reg[REG_MIN_SIZE] - 1)));
      b = BYTE_W'(code_reg[REG_MIN_SIZE] + plen);
      push_byte(b);
      sum = sum + b;
      if (kind < 23) begin
        do b = BYTE_W'($urandom_range(255)); while (sub_hit(b));
        push_byte(b);
      end else begin
        b = code_reg[REG_SUB_WAKEUP + $urandom_range(3)];
        push_byte(b);
        sum = sum + b;
        for (int i = 0; i < plen; i++) begin
          b = BYTE_W'($urandom_range(255));
          push_byte(b);
          sum = sum + b;
        end
        if (kind < 33) b = BYTE_W'($urandom_range(255));
        else b = 8'h00 - sum;
        push_byte(b);
      end
    end
  endtask

  // Predict on every input transaction; track register writes
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tfcp_result_t pred;
      pred = parse_byte(in_ch.rx_byte);
      result_q.push_back(cur_known ? cur_want : pred);
    end
    if (rst_n && cfg_ch.valid && cfg_ch.ready && cfg_ch.index < REG_COUNT)
      code_reg[cfg_ch.index] = cfg_ch.data;
  end

  // Check every output transaction against the oldest expected result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tfcp_result_t want;
      if (result_q.size() == 0) begin
        report_error("result with nothing expected");
      end else begin
        want = result_q.pop_front();
        compare_field("frame_status", 16'(out_ch.frame_status), 16'(want.frame_status));
        compare_field("frame_type", 16'(out_ch.frame_type), 16'(want.frame_type));
        compare_field("frame_subtype", 16'(out_ch.frame_subtype), 16'(want.frame_subtype));
        compare_field("frame_size", 16'(out_ch.frame_size), 16'(want.frame_size));
        compare_field("payload_valid", 16'(out_ch.payload_valid), 16'(want.payload_valid));
        compare_field("payload_byte", 16'(out_ch.payload_byte), 16'(want.payload_byte));
        compare_field("payload_index", 16'(out_ch.payload_index), 16'(want.payload_index));
        compare_field("good_frames", out_ch.good_frames, want.good_frames);
        compare_field("bad_frames", out_ch.bad_frames, want.bad_frames);
      end
    end
  end

  // Receiver: random stalls, forced low during a hold-off
  always @(posedge clk) begin
    out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Count down the hold-off
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int phase_start;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    cur_known     = 1'b0;
    cur_want      = '0;
    hold_left     = 0;
    items_sent    = 0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    send_idle_pct = 20;
    stall_pct     = 20;
    reset_model();

    // Directed rows under reset register values; known results are typed in
    add_row(ROW_BYTE, '0, 8'h00, 1'b1, known_result(ST_NONE, 8'h00, 8'h00, 8'h00, 0, 0));
    add_row(ROW_BYTE, '0, 8'h02, 1'b1, known_result(ST_NONE, 8'h02, 8'h00, 8'h00, 0, 0));
    // undersized size byte is skipped
    add_row(ROW_BYTE, '0, 8'h03, 1'b1, known_result(ST_NONE, 8'h02, 8'h00, 8'h00, 0, 0));
    add_row(ROW_BYTE, '0, 8'h04, 1'b1, known_result(ST_NONE, 8'h02, 8'h00, 8'h04, 0, 0));
    // empty payload: checksum follows the subtype
    add_row(ROW_BYTE, '0, 8'h00, 1'b1, known_result(ST_NONE, 8'h02, 8'h00, 8'h04, 0, 0));
    add_row(ROW_BYTE, '0, 8'hFA, 1'b1, known_result(ST_OK, 8'h02, 8'h00, 8'h04, 1, 0));
    // bad subtype counts as bad and restarts
    add_row(ROW_BYTE, '0, 8'hFE, 1'b1, known_result(ST_NONE, 8'hFE, 8'h00, 8'h04, 1, 0));
    add_row(ROW_BYTE, '0, 8'h05, 1'b1, known_result(ST_NONE, 8'hFE, 8'h00, 8'h05, 1, 0));
    add_row(ROW_BYTE, '0, 8'h01, 1'b1, known_result(ST_NONE, 8'hFE, 8'h00, 8'h05, 1, 1));
    // two-byte payload at the byte extremes, wrong checksum
    add_row(ROW_BYTE, '0, 8'h72, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h06, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'hFF, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h00, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'hFF, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h8B, 1'b0, '0);
    // minimum size changed mid-frame: payload length already fixed
    add_row(ROW_BYTE, '0, 8'h02, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h05, 1'b0, '0);
    add_row(ROW_REG, REG_MIN_SIZE, 8'h00, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h71, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h55, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h33, 1'b0, '0);
    // out-of-range register index is ignored
    add_row(ROW_REG, CFG_IDX_W'(REG_COUNT), 8'hFF, 1'b0, '0);
    // zero minimum size: size byte zero is legal
    add_row(ROW_BYTE, '0, 8'hFE, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h00, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h72, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'h90, 1'b0, '0);
    add_row(ROW_BYTE, '0, 8'hFF, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        settle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        push_byte(dir_tab[i].value, dir_tab[i].known, dir_tab[i].want);
      end
    end

    // Random phases, each with its own register setting and idle mix
    for (int p = 0; p < 4; p++) begin
      foreach (next_cfg[i]) next_cfg[i] = BYTE_W'($urandom_range(255));
      case (p)
        0: begin
          next_cfg = '{8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h01};
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          next_cfg[REG_MIN_SIZE] = BYTE_W'($urandom_range(8, 1));
          send_idle_pct = 55;
          stall_pct     = 0;
        end
        2: begin
          next_cfg[REG_TYPE_QUERY]    = 8'h55;
          next_cfg[REG_TYPE_RESPONSE] = 8'h55;
          next_cfg[REG_TYPE_WAKEUP]   = 8'h55;
          next_cfg[REG_MIN_SIZE]      = 8'hFF;
          send_idle_pct = 0;
          stall_pct     = 55;
        end
        default: begin
          next_cfg[REG_MIN_SIZE] = 8'h00;
          send_idle_pct = 31;
          stall_pct     = 31;
        end
      endcase
      apply_config();
      // Long receiver hold-off while the sender keeps offering bytes
      if (p == 0) hold_left <= 150;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_frame();
    end

    settle();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
